// ===== src/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none
package hsv_pkg;

   localparam int HUE_W   = 16;
   localparam int SAT_W   = 17;
   localparam int VAL_W   = 17;
   localparam int CHAN_W  = 8;
   localparam int CHROMA_W = SAT_W + VAL_W;  // v*s, 32 fraction bits
   localparam int OFFSET_W = CHROMA_W + 2;   // signed m = (v << 16) - C
   localparam int WEIGHT_W = 12;             // 0..3840
   localparam int PART_W   = CHROMA_W + WEIGHT_W;
   localparam int SCALED_W = PART_W + 4;     // signed sum of part and m*3840

   // hue in 1/64 degree
   localparam logic [HUE_W-2:0] HUE_SECTOR = 15'd3840;
   localparam logic [HUE_W-2:0] HUE_FULL   = 15'd23040;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW  = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN  = 3'd2,
      SEC_CYAN_BLUE   = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic       gray;
      sector_type sector;
   } hue_ctl_type;

endpackage
`default_nettype wire

// ===== src/hsv_prep.sv =====
// First stage: chroma multiply and hue sector / weight decode.
`timescale 1ns / 1ps
`default_nettype none
module hsv_prep (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic [hsv_pkg::HUE_W-1:0]        hue,
   input  wire logic [hsv_pkg::SAT_W-1:0]        saturation,
   input  wire logic [hsv_pkg::VAL_W-1:0]        brightness,
   output logic                                  out_valid,
   output hsv_pkg::hue_ctl_type                  out_ctl,
   output logic [hsv_pkg::WEIGHT_W-1:0]          out_weight,
   output logic [hsv_pkg::CHROMA_W-1:0]          out_chroma,
   output logic [hsv_pkg::VAL_W-1:0]             out_value
);
   import hsv_pkg::*;

   logic                  valid_ff;
   hue_ctl_type           ctl_ff, ctl_in;
   logic [WEIGHT_W-1:0]   weight_ff, weight_in;
   logic [CHROMA_W-1:0]   chroma_ff, chroma_in;
   logic [VAL_W-1:0]      value_ff;
   logic [HUE_W-2:0]      hue_mag;
   logic [HUE_W-2:0]      hue_rem;
   logic [WEIGHT_W-1:0]   hue_dist;

   always_comb begin
      hue_mag = hue[HUE_W-2:0];
      ctl_in.gray = hue[HUE_W-1] || (hue_mag > HUE_FULL);

      // sectors are closed on their upper side
      if (hue_mag <= HUE_SECTOR) begin
         ctl_in.sector = SEC_RED_YELLOW;
      end else if (hue_mag <= HUE_SECTOR * 2) begin
         ctl_in.sector = SEC_YELLOW_GREEN;
      end else if (hue_mag <= HUE_SECTOR * 3) begin
         ctl_in.sector = SEC_GREEN_CYAN;
      end else if (hue_mag <= HUE_SECTOR * 4) begin
         ctl_in.sector = SEC_CYAN_BLUE;
      end else if (hue_mag <= HUE_SECTOR * 5) begin
         ctl_in.sector = SEC_BLUE_MAGENTA;
      end else begin
         ctl_in.sector = SEC_MAGENTA_RED;
      end

      // hue mod 120 degrees, only meaningful inside the circle
      if (hue_mag < HUE_SECTOR * 2) begin
         hue_rem = hue_mag;
      end else if (hue_mag < HUE_SECTOR * 4) begin
         hue_rem = hue_mag - HUE_SECTOR * 2;
      end else if (hue_mag < HUE_FULL) begin
         hue_rem = hue_mag - HUE_SECTOR * 4;
      end else begin
         hue_rem = '0;
      end

      if (hue_rem >= HUE_SECTOR) begin
         hue_dist = WEIGHT_W'(hue_rem - HUE_SECTOR);
      end else begin
         hue_dist = WEIGHT_W'(HUE_SECTOR - hue_rem);
      end
      weight_in = WEIGHT_W'(HUE_SECTOR) - hue_dist;

      chroma_in = CHROMA_W'(brightness) * CHROMA_W'(saturation);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ctl_ff    <= ctl_in;
      weight_ff <= weight_in;
      chroma_ff <= chroma_in;
      value_ff  <= brightness;
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_weight = weight_ff;
   assign out_chroma = chroma_ff;
   assign out_value  = value_ff;

endmodule
`default_nettype wire

// ===== src/hsv_mix.sv =====
// Second and third stages: scaled chroma, X and offset, placed per channel.
`timescale 1ns / 1ps
`default_nettype none
module hsv_mix (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire hsv_pkg::hue_ctl_type                 in_ctl,
   input  wire logic [hsv_pkg::WEIGHT_W-1:0]         in_weight,
   input  wire logic [hsv_pkg::CHROMA_W-1:0]         in_chroma,
   input  wire logic [hsv_pkg::VAL_W-1:0]            in_value,
   output logic                                      out_valid,
   output logic signed [hsv_pkg::SCALED_W-1:0]       out_red,
   output logic signed [hsv_pkg::SCALED_W-1:0]       out_green,
   output logic signed [hsv_pkg::SCALED_W-1:0]       out_blue
);
   import hsv_pkg::*;

   localparam int MM_W = OFFSET_W + WEIGHT_W;

   // stage 2
   logic                        valid2_ff;
   hue_ctl_type                 ctl2_ff;
   logic [PART_W-1:0]           cs_ff, cs_in;
   logic [PART_W-1:0]           xs_ff, xs_in;
   logic signed [OFFSET_W-1:0]  m_ff, m_in;

   // stage 3
   logic                        valid3_ff;
   logic signed [SCALED_W-1:0]  red_ff, red_in;
   logic signed [SCALED_W-1:0]  green_ff, green_in;
   logic signed [SCALED_W-1:0]  blue_ff, blue_in;
   logic signed [MM_W-1:0]      m_ext;
   logic signed [MM_W-1:0]      ms;
   logic [PART_W-1:0]           pr, pg, pb;

   always_comb begin
      // C * 3840 = C*4096 - C*256
      cs_in = {in_chroma, 12'b0} - {4'b0, in_chroma, 8'b0};
      xs_in = PART_W'(in_chroma) * PART_W'(in_weight);
      m_in  = $signed({3'b0, in_value, 16'b0}) - $signed({2'b0, in_chroma});
   end

   always_comb begin
      m_ext = MM_W'(m_ff);
      ms    = (m_ext <<< 12) - (m_ext <<< 8);
      pr = '0;
      pg = '0;
      pb = '0;
      if (!ctl2_ff.gray) begin
         case (ctl2_ff.sector)
            SEC_RED_YELLOW: begin
               pr = cs_ff; pg = xs_ff;
            end
            SEC_YELLOW_GREEN: begin
               pr = xs_ff; pg = cs_ff;
            end
            SEC_GREEN_CYAN: begin
               pg = cs_ff; pb = xs_ff;
            end
            SEC_CYAN_BLUE: begin
               pg = xs_ff; pb = cs_ff;
            end
            SEC_BLUE_MAGENTA: begin
               pr = xs_ff; pb = cs_ff;
            end
            SEC_MAGENTA_RED: begin
               pr = cs_ff; pb = xs_ff;
            end
            default: begin
               pr = '0;
            end
         endcase
      end
      red_in   = $signed({4'b0, pr}) + SCALED_W'(ms);
      green_in = $signed({4'b0, pg}) + SCALED_W'(ms);
      blue_in  = $signed({4'b0, pb}) + SCALED_W'(ms);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
      end
      ctl2_ff  <= in_ctl;
      cs_ff    <= cs_in;
      xs_ff    <= xs_in;
      m_ff     <= m_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_valid = valid3_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule
`default_nettype wire

// ===== src/hsv_quant.sv =====
// Final stage for one channel: floor(255*T / (3840 * 2^32)) with clamping.
`timescale 1ns / 1ps
`default_nettype none
module hsv_quant (
   input  wire logic                                 clock,
   input  wire logic signed [hsv_pkg::SCALED_W-1:0]  scaled,
   output logic [hsv_pkg::CHAN_W-1:0]                level
);
   import hsv_pkg::*;

   localparam int PROD_W = SCALED_W + 5;
   localparam int SHIFT  = 40;

   logic signed [PROD_W-1:0]     prod;
   logic [PROD_W-SHIFT-1:0]      whole;
   logic [CHAN_W-1:0]            level_ff, level_in;

   always_comb begin
      // 255 / 3840 = 17 / 256, so the result is 17*T >> 40
      prod  = (PROD_W'(scaled) <<< 4) + PROD_W'(scaled);
      whole = prod[PROD_W-1:SHIFT];
      if (scaled[SCALED_W-1] || (scaled == '0)) begin
         level_in = '0;
      end else if (whole > (PROD_W-SHIFT)'(255)) begin
         level_in = '1;
      end else begin
         level_in = whole[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule
`default_nettype wire

// ===== src/hsv_to_rgb_unit.sv =====
// Top level of the HSV to 8-bit RGB converter.
//
// One request is taken in every clock cycle while start is high; busy is
// always low. Each request gives exactly one result on the rsp_ ports, marked
// by rsp_valid for one cycle, in request order. Each result passes four
// register stages: the chroma multiplier with hue decode, the C/X products,
// the per-channel sum, and the final scaling. The receiver cannot hold
// results off, so nothing stalls.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [hsv_pkg::HUE_W-1:0]         req_hue,
   input  wire logic [hsv_pkg::SAT_W-1:0]         req_saturation,
   input  wire logic [hsv_pkg::VAL_W-1:0]         req_brightness,
   output logic                                   rsp_valid,
   output logic [hsv_pkg::CHAN_W-1:0]             rsp_red,
   output logic [hsv_pkg::CHAN_W-1:0]             rsp_green,
   output logic [hsv_pkg::CHAN_W-1:0]             rsp_blue
);
   import hsv_pkg::*;

   logic                        accept;
   logic                        p_valid;
   hue_ctl_type                 p_ctl;
   logic [WEIGHT_W-1:0]         p_weight;
   logic [CHROMA_W-1:0]         p_chroma;
   logic [VAL_W-1:0]            p_value;
   logic                        m_valid;
   logic signed [SCALED_W-1:0]  m_red, m_green, m_blue;
   logic                        valid4_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hsv_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (p_valid),
      .out_ctl    (p_ctl),
      .out_weight (p_weight),
      .out_chroma (p_chroma),
      .out_value  (p_value)
   );

   hsv_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ctl    (p_ctl),
      .in_weight (p_weight),
      .in_chroma (p_chroma),
      .in_value  (p_value),
      .out_valid (m_valid),
      .out_red   (m_red),
      .out_green (m_green),
      .out_blue  (m_blue)
   );

   hsv_quant u_quant_red (
      .clock  (clock),
      .scaled (m_red),
      .level  (rsp_red)
   );

   hsv_quant u_quant_green (
      .clock  (clock),
      .scaled (m_green),
      .level  (rsp_green)
   );

   hsv_quant u_quant_blue (
      .clock  (clock),
      .scaled (m_blue),
      .level  (rsp_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= m_valid;
      end
   end

   assign rsp_valid = valid4_ff;

endmodule
`default_nettype wire

// ===== src/hsv_to_rgb_checker.sv =====
// Port-level checks for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hsv_to_rgb_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [hsv_pkg::HUE_W-1:0]         req_hue,
   input  wire logic [hsv_pkg::SAT_W-1:0]         req_saturation,
   input  wire logic [hsv_pkg::VAL_W-1:0]         req_brightness,
   input  wire logic                              rsp_valid,
   input  wire logic [hsv_pkg::CHAN_W-1:0]        rsp_red,
   input  wire logic [hsv_pkg::CHAN_W-1:0]        rsp_green,
   input  wire logic [hsv_pkg::CHAN_W-1:0]        rsp_blue
);
   import hsv_pkg::*;

   // every accepted request comes out as a result
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("request lost");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without request");

   // zero saturation is gray
   a_no_sat_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_saturation, 4) == '0)) |->
         (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("unsaturated color not gray");

   // negative hue is gray
   a_neg_hue_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_hue[HUE_W-1], 4)) |->
         (rsp_red == rsp_green) && (rsp_green == rsp_blue))
      else $error("hue outside circle not gray");

   // zero brightness is black
   a_dark_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_brightness, 4) == '0)) |->
         (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
      else $error("zero brightness not black");

endmodule

bind hsv_to_rgb_unit hsv_to_rgb_checker u_hsv_chk (.*);
`default_nettype wire

// ===== sim/hsv_to_rgb_unit_tb.sv =====
// Self-checking testbench for the HSV to 8-bit RGB converter.
`timescale 1ns / 1ps
module hsv_to_rgb_unit_tb;
   import hsv_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   localparam longint SECTOR   = longint'(HUE_SECTOR);
   localparam longint FULL_HUE = longint'(HUE_FULL);
   localparam longint UNITY    = 64'sd65536;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [HUE_W-1:0] req_hue;
   logic [SAT_W-1:0] req_saturation;
   logic [VAL_W-1:0] req_brightness;
   logic rsp_valid;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;

   rgb_type pending_rgb[$];
   rgb_type want_rgb;
   int accepted_count = 0;
   int mismatch_count = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;

   hsv_to_rgb_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor(255*(part + m)) over 3840 * 2^32, clamped to 0..255
   function automatic logic [CHAN_W-1:0] scale_channel(longint part, longint offset);
      longint num;
      longint q;
      num = 255 * (part + offset);
      if (num <= 0) return '0;
      q = num / (SECTOR * 64'sd4294967296);
      if (q > 255) q = 255;
      return q[CHAN_W-1:0];
   endfunction

   function automatic rgb_type rgb_of_hsv(logic [HUE_W-1:0] hue, logic [SAT_W-1:0] sat,
                                          logic [VAL_W-1:0] val);
      longint h, chroma, offset, c_part, x_part, hue_dist;
      longint pr, pg, pb;
      rgb_type rgb;
      h = longint'($signed(hue));
      chroma = longint'(val) * longint'(sat);
      offset = (longint'(val) * UNITY - chroma) * SECTOR;
      c_part = chroma * SECTOR;
      pr = 0;
      pg = 0;
      pb = 0;
      // outside the circle stays gray
      if (h >= 0 && h <= FULL_HUE) begin
         hue_dist = (h % (2 * SECTOR)) - SECTOR;
         if (hue_dist < 0) hue_dist = -hue_dist;
         x_part = chroma * (SECTOR - hue_dist);
         if (h <= SECTOR) begin
            pr = c_part; pg = x_part;
         end else if (h <= 2 * SECTOR) begin
            pr = x_part; pg = c_part;
         end else if (h <= 3 * SECTOR) begin
            pg = c_part; pb = x_part;
         end else if (h <= 4 * SECTOR) begin
            pg = x_part; pb = c_part;
         end else if (h <= 5 * SECTOR) begin
            pr = x_part; pb = c_part;
         end else begin
            pr = c_part; pb = x_part;
         end
      end
      rgb.red   = scale_channel(pr, offset);
      rgb.green = scale_channel(pg, offset);
      rgb.blue  = scale_channel(pb, offset);
      return rgb;
   endfunction

   // Result check, then capture of the request accepted at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid !== 1'b0) begin
            if (pending_rgb.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result r=%0d g=%0d b=%0d", rsp_red, rsp_green, rsp_blue);
            end else begin
               want_rgb = pending_rgb.pop_front();
               if (rsp_red !== want_rgb.red || rsp_green !== want_rgb.green ||
                   rsp_blue !== want_rgb.blue) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                              want_rgb.red, want_rgb.green, want_rgb.blue,
                              rsp_red, rsp_green, rsp_blue);
               end
            end
         end
         if (start && busy === 1'b0) begin
            pending_rgb.push_back(rgb_of_hsv(req_hue, req_saturation, req_brightness));
            accepted_count++;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge once accepted and after any idle gap
   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                             input logic [VAL_W-1:0] val);
      int taken;
      taken = accepted_count;
      start = 1'b1;
      req_hue = hue;
      req_saturation = sat;
      req_brightness = val;
      do @(negedge clock); while (accepted_count == taken);
      if (gaps_on) begin
         if (burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 7)) begin
               req_hue = HUE_W'($urandom);
               req_saturation = SAT_W'($urandom);
               req_brightness = VAL_W'($urandom);
               @(negedge clock);
            end
            burst_left = $urandom_range(0, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain;
      start = 1'b0;
      while (pending_rgb.size() != 0) @(negedge clock);
   endtask

   function automatic logic [SAT_W-1:0] pick_unit(bit allow_over);
      int sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return '0;
      if (sel == 1) return SAT_W'(UNITY);
      if (allow_over && sel <= 4) return SAT_W'($urandom_range(65537, 131071));
      return SAT_W'($urandom_range(0, 65536));
   endfunction

   task automatic test_directed;
      logic [HUE_W-1:0] hues[14];
      hues = '{16'd0, 16'd1920, 16'd3840, 16'd3841, 16'd7680, 16'd7681, 16'd11520,
               16'd15360, 16'd19200, 16'd23040, 16'd23041, 16'hFFFF, 16'h8000, 16'h7FFF};
      foreach (hues[i]) send_pixel(hues[i], 17'd65536, 17'd65536);
      send_pixel(16'd5000, 17'd0, 17'd40000);          // gray from zero saturation
      send_pixel(16'd9000, 17'd50000, 17'd0);          // black
      send_pixel(16'd1920, 17'h1FFFF, 17'd65536);      // saturation above one
      send_pixel(16'd13000, 17'd0, 17'h1FFFF);         // brightness above one
      send_pixel(16'd20000, 17'd65536, 17'h1FFFF);
      send_pixel(16'd17280, 17'h1FFFF, 17'h1FFFF);
      send_pixel(16'hFFFF, 17'd30000, 17'h1FFFF);      // gray, clamped high
      send_pixel(16'h8000, 17'h1FFFF, 17'd65536);      // gray, clamped low
      drain();
   endtask

   task automatic test_in_circle(input int count);
      repeat (count)
         send_pixel(HUE_W'($urandom_range(0, 23040)), pick_unit(1'b0), pick_unit(1'b0));
      drain();
   endtask

   task automatic test_sector_edges(input int count);
      int k;
      repeat (count) begin
         k = $urandom_range(0, 6) * 3840 + $urandom_range(0, 4) - 2;
         send_pixel(k[HUE_W-1:0], pick_unit(1'b0), pick_unit(1'b0));
      end
      drain();
   endtask

   task automatic test_full_range(input int count);
      repeat (count) send_pixel(HUE_W'($urandom), pick_unit(1'b1), pick_unit(1'b1));
      drain();
   endtask

   task automatic test_full_rate(input int count);
      gaps_on = 1'b0;
      repeat (count)
         send_pixel(HUE_W'($urandom_range(0, 23040)), pick_unit(1'b0), pick_unit(1'b0));
      gaps_on = 1'b1;
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_hue = '0;
      req_saturation = '0;
      req_brightness = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_in_circle(800);
      test_sector_edges(150);
      test_full_range(300);
      test_full_rate(250);
      repeat (12) @(negedge clock);
      if (mismatch_count == 0 && pending_rgb.size() == 0)
         $display("[hsv_to_rgb_unit] OK");
      else
         $display("[hsv_to_rgb_unit] ERROR");
      $finish;
   end

   initial begin
      #200000;
      $display("[hsv_to_rgb_unit] ERROR");
      $finish;
   end

endmodule
